// ----- design/qste_pkg.sv -----
// Shared definitions for the queue/stack transfer engine.
// Holds request and status codes and the fixed beat field widths.
// No dependencies.
package qste_pkg;

   localparam int OpW     = 3;
   localparam int PieceW  = 8;
   localparam int StatusW = 3;
   localparam int CountW  = 5;

   localparam int ReqDataW = 16;
   localparam int RspDataW = 24;

   typedef logic [OpW-1:0]     op_type;
   typedef logic [StatusW-1:0] status_type;

   localparam op_type OP_ENQ  = 3'd0;
   localparam op_type OP_DEQ  = 3'd1;
   localparam op_type OP_Q2S  = 3'd2;
   localparam op_type OP_S2Q  = 3'd3;
   localparam op_type OP_SWAP = 3'd4;

   localparam status_type ST_OK      = 3'd0;
   localparam status_type ST_Q_EMPTY = 3'd1;
   localparam status_type ST_Q_FULL  = 3'd2;
   localparam status_type ST_S_EMPTY = 3'd3;
   localparam status_type ST_S_LOST  = 3'd4;
   localparam status_type ST_SWAP_NO = 3'd5;

endpackage

// ----- design/queue_stack_transfer_engine.sv -----
// A result beat is registered in S_EXEC after the request beat is accepted, once no earlier
// result beat is held back by rsp_tready. No new request is accepted until S_EXEC completes:
// the queue and stack memories are read on acceptance, ahead of the read-modify-write in S_EXEC.
// A request is accepted while the previous result beat still waits on rsp_tready.
// Reset clears pointers, fill counts and handshake state; memory contents are not cleared.
// Depends on qste_pkg.
module queue_stack_transfer_engine
   import qste_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int PIECE_BITS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ReqDataW-1:0] req_tdata,  // req_type[2:0], piece_in[10:3], zero
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata   // piece_out[7:0], status[10:8],
                                           // queue_count[15:11], stack_count[20:16], zero
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LastSlot = AW'(DEPTH - 1);
   localparam logic [FW-1:0] FullCnt  = FW'(DEPTH);

   typedef enum logic {S_IDLE, S_EXEC} state_type;

   logic [PIECE_BITS-1:0] qmem [DEPTH];
   logic [PIECE_BITS-1:0] smem [DEPTH];

   state_type             state_ff;
   op_type                op_ff;
   logic [PIECE_BITS-1:0] piece_ff, piece_in;
   logic [AW-1:0]         head_ff, head_in, tail_ff, tail_in;
   logic [FW-1:0]         qfill_ff, qfill_in, sfill_ff, sfill_in;
   logic [PIECE_BITS-1:0] qrd_ff, srd_ff;
   logic                  rsp_valid_ff;
   logic [RspDataW-1:0]   rsp_data_ff, rsp_data_in;

   logic                  accept, fire;
   logic [AW-1:0]         s_rd_addr, top_addr, q_wr_addr, s_wr_addr;
   logic                  q_we, s_we;
   logic [PIECE_BITS-1:0] q_wd, s_wd;
   logic [PieceW-1:0]     pout;
   status_type            status;
   logic [CountW-1:0]     qcnt, scnt;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign fire       = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign top_addr  = AW'(sfill_ff - FW'(1));
   assign s_rd_addr = (sfill_ff == '0) ? '0 : top_addr;

   always_comb begin
      piece_in = '0;
      for (int i = 0; i < PIECE_BITS; i++) begin
         if (i < PieceW) begin
            piece_in[i] = req_tdata[OpW + i];
         end
      end
   end

   always_ff @(posedge clock) begin
      qrd_ff <= qmem[head_ff];
      srd_ff <= smem[s_rd_addr];
      if (q_we) begin
         qmem[q_wr_addr] <= q_wd;
      end
      if (s_we) begin
         smem[s_wr_addr] <= s_wd;
      end
   end

   always_comb begin
      logic [AW-1:0] tail_nx;
      logic [AW-1:0] head_nx;
      tail_nx   = (tail_ff == LastSlot) ? '0 : tail_ff + AW'(1);
      head_nx   = (head_ff == LastSlot) ? '0 : head_ff + AW'(1);
      head_in   = head_ff;
      tail_in   = tail_ff;
      qfill_in  = qfill_ff;
      sfill_in  = sfill_ff;
      q_we      = 1'b0;
      s_we      = 1'b0;
      q_wr_addr = tail_nx;
      s_wr_addr = AW'(sfill_ff);
      q_wd      = piece_ff;
      s_wd      = qrd_ff;
      pout      = '0;
      status    = ST_OK;
      case (op_ff)
         OP_ENQ: begin
            if (qfill_ff == FullCnt) begin
               status = ST_Q_FULL;
            end else begin
               q_we     = 1'b1;
               tail_in  = tail_nx;
               qfill_in = qfill_ff + FW'(1);
            end
         end
         OP_DEQ: begin
            if (qfill_ff == '0) begin
               status = ST_Q_EMPTY;
            end else begin
               for (int i = 0; i < PieceW; i++) begin
                  if (i < PIECE_BITS) begin
                     pout[i] = qrd_ff[i];
                  end
               end
               head_in  = head_nx;
               qfill_in = qfill_ff - FW'(1);
            end
         end
         OP_Q2S: begin
            if (qfill_ff == '0) begin
               status = ST_Q_EMPTY;
            end else begin
               head_in  = head_nx;
               qfill_in = qfill_ff - FW'(1);
               if (sfill_ff == FullCnt) begin
                  status = ST_S_LOST;
               end else begin
                  s_we     = 1'b1;
                  sfill_in = sfill_ff + FW'(1);
               end
            end
         end
         OP_S2Q: begin
            if (sfill_ff == '0) begin
               status = ST_S_EMPTY;
            end else begin
               sfill_in = sfill_ff - FW'(1);
               q_wd     = srd_ff;
               if (qfill_ff == FullCnt) begin
                  status = ST_Q_FULL;
               end else begin
                  q_we     = 1'b1;
                  tail_in  = tail_nx;
                  qfill_in = qfill_ff + FW'(1);
               end
            end
         end
         OP_SWAP: begin
            if (qfill_ff == '0 || sfill_ff == '0) begin
               status = ST_SWAP_NO;
            end else begin
               q_we      = 1'b1;
               s_we      = 1'b1;
               q_wr_addr = head_ff;
               q_wd      = srd_ff;
               s_wr_addr = top_addr;
            end
         end
         default: begin
         end
      endcase
      q_we = q_we && fire;
      s_we = s_we && fire;
   end

   always_comb begin
      qcnt = '0;
      scnt = '0;
      for (int i = 0; i < CountW; i++) begin
         if (i < FW) begin
            qcnt[i] = qfill_in[i];
            scnt[i] = sfill_in[i];
         end
      end
      rsp_data_in = {{(RspDataW - PieceW - StatusW - 2 * CountW){1'b0}},
                     scnt, qcnt, status, pout};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= LastSlot;
         qfill_ff     <= '0;
         sfill_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && !fire) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               if (fire) begin
                  state_ff     <= S_IDLE;
                  head_ff      <= head_in;
                  tail_ff      <= tail_in;
                  qfill_ff     <= qfill_in;
                  sfill_ff     <= sfill_in;
                  rsp_valid_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_tdata[OpW-1:0];
         piece_ff <= piece_in;
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
